// ===== sv/module_announce_deframer_core_defines.svh =====
// Assertion macros for the module announcement deframer.
// Depends on nothing; included by module_announce_deframer_core, which carries the assertions.
`ifndef MODULE_ANNOUNCE_DEFRAMER_CORE_DEFINES_SVH
`define MODULE_ANNOUNCE_DEFRAMER_CORE_DEFINES_SVH

// Checks a property on every rising edge of clk outside reset.
`define MAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition is always followed by another in the next cycle.
`define MAD_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== sv/mad_pkg.sv =====
// Types and constants for the module announcement deframer.
// Depends on nothing; imported by module_announce_deframer_core and tb_top.
package mad_pkg;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TYPE   = 2'd1,
    PH_RECORD = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  localparam logic [7:0] ANNOUNCE_TYPE = 8'h18;
  localparam logic [7:0] MIN_LENGTH    = 8'd2;
  localparam logic [7:0] RECORD_BYTES  = 8'd8;

  typedef struct packed {
    logic [31:0] address;
    logic [15:0] kind;
    logic [15:0] version;
  } record_t;

endpackage

// ===== sv/module_announce_deframer_core.sv =====
// Module announcement deframer: parses length-prefixed packets from received
// bytes and emits one record per announcement packet.
// Depends on mad_pkg and module_announce_deframer_core_defines.svh.
//
// Usage:
// The input channel (in_valid, in_stall, in_rx_byte) takes one received byte
// per item. The result channel (out_valid, out_stall, out_module_*) delivers
// one announcement record for each packet of type 0x18, on the eighth body
// byte of that packet. All other bytes produce no result.
// Throughput is one byte per cycle while in_stall is low. When its last
// byte is accepted, a record is registered in the result register, or in
// the skid register if the receiver stalls. Parser state and result register
// sit behind a single pass of logic; the byte rate is set by that and in_stall.
// A skid register behind the result register lets one further record be
// held while a record waits on a stalled receiver; in_stall rises only
// once that skid register also holds a record, and falls in the cycle after
// the receiver drains it.
// Reset (rst_n low, synchronous) returns the parser to waiting for a length
// byte and empties both result registers.
`include "module_announce_deframer_core_defines.svh"

module module_announce_deframer_core
  import mad_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_module_address,
  output logic [15:0] out_module_kind,
  output logic [15:0] out_module_version
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_length_r, held_length_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [63:0] record_shift_r, record_shift_nxt;

  logic        out_valid_r;
  record_t     out_rec_r;
  logic        skid_valid_r;
  record_t     skid_rec_r;

  logic        accept;
  logic        produce;
  logic [7:0]  left_dec;
  logic [63:0] shifted;
  record_t     new_rec;
  logic        out_free;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  // Count down, holding at zero rather than wrapping.
  assign left_dec = (bytes_left_r == 8'd0) ? 8'd0 : bytes_left_r - 8'd1;
  assign shifted  = {record_shift_r[55:0], in_rx_byte};

  // Next state of the parser.
  always_comb begin
    phase_nxt        = phase_r;
    held_length_nxt  = held_length_r;
    bytes_left_nxt   = bytes_left_r;
    record_shift_nxt = record_shift_r;
    if (accept) begin
      unique case (phase_r)
        PH_LENGTH: begin
          if (in_rx_byte >= MIN_LENGTH) begin
            held_length_nxt = in_rx_byte;
            phase_nxt       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (in_rx_byte == ANNOUNCE_TYPE) begin
            bytes_left_nxt   = RECORD_BYTES;
            record_shift_nxt = '0;
            phase_nxt        = PH_RECORD;
          end else begin
            bytes_left_nxt = held_length_r - MIN_LENGTH;
            phase_nxt      = (held_length_r == MIN_LENGTH) ? PH_LENGTH : PH_SKIP;
          end
        end
        PH_RECORD: begin
          record_shift_nxt = shifted;
          bytes_left_nxt   = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_LENGTH;
          end
        end
        PH_SKIP: begin
          bytes_left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_LENGTH;
          end
        end
        default: begin
          phase_nxt = PH_LENGTH;
        end
      endcase
    end
  end

  // Result of the current byte.
  always_comb begin
    produce         = accept && (phase_r == PH_RECORD) && (left_dec == 8'd0);
    new_rec.address = shifted[63:32];
    new_rec.kind    = shifted[31:16];
    new_rec.version = shifted[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_LENGTH;
      held_length_r  <= '0;
      bytes_left_r   <= '0;
      record_shift_r <= '0;
    end else begin
      phase_r        <= phase_nxt;
      held_length_r  <= held_length_nxt;
      bytes_left_r   <= bytes_left_nxt;
      record_shift_r <= record_shift_nxt;
    end
  end

  // Result register with a skid stage. A new record cannot arrive while the
  // skid register is full, since the input is stalled then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= produce;
      end
    end else if (produce) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_rec_r <= skid_rec_r;
      end else if (produce) begin
        out_rec_r <= new_rec;
      end
    end else if (produce) begin
      skid_rec_r <= new_rec;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_module_address = out_rec_r.address;
  assign out_module_kind    = out_rec_r.kind;
  assign out_module_version = out_rec_r.version;

  `MAD_ASSERT(a_skid_implies_out, skid_valid_r |-> out_valid_r, "skid full while output empty")
  `MAD_ASSERT(a_record_count, (phase_r == PH_RECORD) |-> (bytes_left_r != 8'd0 && bytes_left_r <= RECORD_BYTES), "announcement byte count out of range")
  `MAD_ASSERT_NEXT(a_back_to_header, produce, phase_r == PH_LENGTH, "parser did not return to header after a record")
  `MAD_ASSERT_NEXT(a_skid_held, skid_valid_r && out_stall, skid_valid_r && out_valid_r, "held record lost under stall")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for module_announce_deframer_core: a byte-level packet
// model predicts every announcement record and checks it against the result port.
// Depends on mad_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_top;
  import mad_pkg::*;

  // Follows the packet parser byte by byte and keeps the records still owed.
  class announce_tracker;
    phase_t      phase;
    logic [7:0]  held_length;
    logic [7:0]  bytes_left;
    logic [63:0] record_shift;
    record_t     owed_records[$];
    int          errors;

    function new();
      phase        = PH_LENGTH;
      held_length  = '0;
      bytes_left   = '0;
      record_shift = '0;
      errors       = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PH_LENGTH: begin
          if (b >= MIN_LENGTH) begin
            held_length = b;
            phase       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (b == ANNOUNCE_TYPE) begin
            bytes_left   = RECORD_BYTES;
            record_shift = '0;
            phase        = PH_RECORD;
          end else begin
            bytes_left = held_length - MIN_LENGTH;
            phase      = (bytes_left == 8'd0) ? PH_LENGTH : PH_SKIP;
          end
        end
        PH_RECORD: begin
          record_shift = {record_shift[55:0], b};
          bytes_left   = (bytes_left == 8'd0) ? 8'd0 : bytes_left - 8'd1;
          if (bytes_left == 8'd0) begin
            phase        = PH_LENGTH;
            owed_records = {owed_records, record_t'(record_shift)};
          end
        end
        default: begin
          bytes_left = (bytes_left == 8'd0) ? 8'd0 : bytes_left - 8'd1;
          if (bytes_left == 8'd0) phase = PH_LENGTH;
        end
      endcase
    endfunction

    function void match_record(logic [31:0] address, logic [15:0] kind,
                               logic [15:0] version);
      record_t want;
      if (owed_records.size() == 0) begin
        $error("unexpected record: address %h kind %h version %h", address, kind, version);
        errors++;
        return;
      end
      want = owed_records.pop_front();
      if (address !== want.address) begin
        $error("module_address: expected %h, got %h", want.address, address);
        errors++;
      end
      if (kind !== want.kind) begin
        $error("module_kind: expected %h, got %h", want.kind, kind);
        errors++;
      end
      if (version !== want.version) begin
        $error("module_version: expected %h, got %h", want.version, version);
        errors++;
      end
    endfunction

    function int owed();
      return owed_records.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_module_address;
  logic [15:0] out_module_kind;
  logic [15:0] out_module_version;

  announce_tracker tracker = new();

  bit tx_no_idle;
  bit rx_no_idle;
  bit rx_hold_req;
  int bytes_sent;

  module_announce_deframer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_module_address (out_module_address),
    .out_module_kind    (out_module_kind),
    .out_module_version (out_module_version)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int draw_gap(bit no_idle);
    return no_idle ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Both handshakes are sampled at the edge, before any of this step's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.match_record(out_module_address, out_module_kind, out_module_version);
      if (in_valid && !in_stall)
        tracker.take_byte(in_rx_byte);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_no_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_announce(input logic [7:0] length, input logic [31:0] address,
                               input logic [15:0] kind, input logic [15:0] version);
    logic [63:0] body;
    body = {address, kind, version};
    send_byte(length);
    send_byte(ANNOUNCE_TYPE);
    for (int i = 7; i >= 0; i--) send_byte(body[i*8 +: 8]);
  endtask

  task automatic send_other(input logic [7:0] length, input logic [7:0] kind_byte);
    send_byte(length);
    send_byte(kind_byte);
    for (int i = 2; i < int'(length); i++) send_byte(8'($urandom));
  endtask

  // Receiver: a drawn stall before each record, plus one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = draw_gap(rx_no_idle);
      if (rx_hold_req) begin
        n           = 300;
        rx_hold_req = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int          pick;
    int          packets;
    logic [7:0]  length;
    logic [7:0]  kind_byte;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = '0;
    tx_no_idle  = 1'b0;
    rx_no_idle  = 1'b0;
    rx_hold_req = 1'b0;
    bytes_sent  = 0;
    packets     = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both filler values, an empty body, a short skip, and announcements
    // at the longest and the shortest length byte with all-ones and all-zeros fields.
    send_byte(8'd0);
    send_byte(8'd1);
    send_other(8'd2, 8'h00);
    send_other(8'd3, 8'hFF);
    send_announce(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_announce(8'd2, 32'h0000_0000, 16'h0000, 16'h0000);

    // Back-to-back announcements against a receiver that holds off for a long time.
    rx_hold_req = 1'b1;
    tx_no_idle  = 1'b1;
    repeat (40) send_announce(8'd10, $urandom, 16'($urandom), 16'($urandom));
    tx_no_idle = 1'b0;

    while (bytes_sent < 1550) begin
      if (packets % 40 == 0) begin
        tx_no_idle = ($urandom_range(0, 3) == 0);
        rx_no_idle = ($urandom_range(0, 3) == 0);
      end
      packets++;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        length = ($urandom_range(0, 9) < 7) ? 8'd10 : 8'($urandom_range(2, 255));
        send_announce(length, $urandom, 16'($urandom), 16'($urandom));
      end else if (pick < 75) begin
        do kind_byte = 8'($urandom); while (kind_byte == ANNOUNCE_TYPE);
        length = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(15, 255))
                                               : 8'($urandom_range(2, 14));
        send_other(length, kind_byte);
      end else if (pick < 85) begin
        send_byte(8'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
